// ===== sv/wscs_pkg.sv =====
// Shared types, constants and helpers for the work-stealing core scheduler.
`default_nettype none
package wscs_pkg;

    localparam int MAX_CORES   = 4;
    localparam int QUEUE_DEPTH = 16;
    localparam int CORE_W      = 2;
    localparam int PTR_W       = 4;
    localparam int SIZE_W      = 5;
    localparam int TASK_W      = 31;
    localparam int ACT_W       = 3;
    localparam int CMD_W       = 3;
    localparam int STAT_W      = 4;
    localparam int ADDR_W      = CORE_W + PTR_W;
    localparam int TOT_W       = 7;
    localparam logic [SIZE_W-1:0] CAP_RESET = SIZE_W'(4);

    typedef enum logic [CMD_W-1:0] {
        CMD_SPAWN    = 3'd0,
        CMD_RUN      = 3'd1,
        CMD_SLEEP    = 3'd2,
        CMD_SHUTDOWN = 3'd3,
        CMD_QUERY    = 3'd4
    } cmd_t;

    typedef enum logic [STAT_W-1:0] {
        ST_ASSIGNED = 4'd0,
        ST_RAN      = 4'd1,
        ST_IDLE     = 4'd2,
        ST_MOVED    = 4'd3,
        ST_NO_MOVE  = 4'd4,
        ST_DELETED  = 4'd5,
        ST_NO_DEL   = 4'd6,
        ST_QUERY    = 4'd7,
        ST_FAIL     = 4'd8
    } res_status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_RUN_POP,
        S_STEAL_CHK,
        S_STEAL_WR,
        S_SLEEP_SEL,
        S_SLEEP_WR,
        S_SHUT_SCAN,
        S_SHUT_POP,
        S_EMIT
    } ctrl_state_t;

    typedef enum logic [3:0] {
        DP_NOP,
        DP_LATCH,
        DP_FAIL,
        DP_SPAWN,
        DP_RUN_INIT,
        DP_RUN_POP,
        DP_STEAL_POP,
        DP_STEAL_PUSH,
        DP_SLEEP_EMPTY,
        DP_SLEEP_POP,
        DP_SLEEP_PUSH,
        DP_QUERY,
        DP_SHUT_EMPTY,
        DP_SHUT_START,
        DP_SHUT_NEXT,
        DP_SHUT_POP
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
        logic   emit;
    } dp_cmd_t;

    typedef struct packed {
        cmd_t cmd;
        logic cid_ok;
        logic cid_has;
        logic spawn_fail;
        logic single_core;
        logic total_zero;
        logic run_steal;
        logic sleep_full;
        logic shut_cur_empty;
        logic last_now;
        logic out_free;
    } dp_stat_t;

    // capacity after a push: doubles, capped at the queue depth, when full
    function automatic logic [SIZE_W-1:0] grow_cap(input logic [SIZE_W-1:0] size,
                                                   input logic [SIZE_W-1:0] cap);
        logic [SIZE_W:0] dbl;
        dbl = {cap, 1'b0};
        if (size == cap)
            grow_cap = (dbl > (SIZE_W+1)'(QUEUE_DEPTH)) ? SIZE_W'(QUEUE_DEPTH)
                                                        : dbl[SIZE_W-1:0];
        else
            grow_cap = cap;
    endfunction

    // capacity after a pop: halves when size sits at one quarter
    function automatic logic [SIZE_W-1:0] shrink_cap(input logic [SIZE_W-1:0] size,
                                                     input logic [SIZE_W-1:0] cap);
        shrink_cap = (size == (cap >> 2)) ? (cap >> 1) : cap;
    endfunction

endpackage
`default_nettype wire

// ===== sv/work_stealing_core_scheduler_unit.sv =====
// Top level of the work-stealing core scheduler.
// Four per-core task deques share one 64-entry task store (16 slots per
// core, kept as rings). One command transaction is taken at a time; it
// yields one or more result transactions, the final one flagged by last.
// in_ready is high only while the sequencer is idle; the result sits in an
// output register, so the next command can be taken while the previous
// result still waits for out_ready. A run pops the front task if there is
// one, then steals one task from the most-loaded core if its own queue is
// empty; a sleep moves its tasks one per result; a shutdown deletes tasks
// one per result and skips empty cores. A stalled result register holds
// the sequencer until that result is taken. Every task read goes through
// the single store read port, whose read data is registered.
// A write to active_cores clears all queues at once (pointers, sizes,
// capacities back to 4); write it only while no command is in flight.
// Store entries are never cleared; only read data from entries holding
// queued tasks is used, so no clearing pass is needed after reset.
`default_nettype none
module work_stealing_core_scheduler_unit (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_wr_en,
    input  wire logic [wscs_pkg::ACT_W-1:0]     cfg_wr_data,
    input  wire logic                           in_valid,
    output logic                                in_ready,
    input  wire logic [wscs_pkg::CMD_W-1:0]     command,
    input  wire logic [wscs_pkg::CORE_W-1:0]    core_id,
    input  wire logic [wscs_pkg::TASK_W-1:0]    task_id,
    output logic                                out_valid,
    input  wire logic                           out_ready,
    output logic      [wscs_pkg::STAT_W-1:0]    status,
    output logic      [wscs_pkg::CORE_W-1:0]    core_id_out,
    output logic      [wscs_pkg::TASK_W-1:0]    task_out,
    output logic      [wscs_pkg::CORE_W-1:0]    other_core,
    output logic                                stole,
    output logic      [wscs_pkg::SIZE_W-1:0]    queue_size,
    output logic      [wscs_pkg::SIZE_W-1:0]    queue_capacity,
    output logic                                last
);
    import wscs_pkg::*;

    dp_cmd_t           cmd;
    dp_stat_t          stat;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [TASK_W-1:0] mem_wdata;
    logic [ADDR_W-1:0] mem_raddr;
    logic [TASK_W-1:0] mem_rdata;

    // sequencer: walks each command through its store accesses
    wscs_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // queue bookkeeping, core selection, result register
    wscs_dp u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .stat           (stat),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .command        (command),
        .core_id        (core_id),
        .task_id        (task_id),
        .mem_we         (mem_we),
        .mem_waddr      (mem_waddr),
        .mem_wdata      (mem_wdata),
        .mem_raddr      (mem_raddr),
        .mem_rdata      (mem_rdata),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .status         (status),
        .core_id_out    (core_id_out),
        .task_out       (task_out),
        .other_core     (other_core),
        .stole          (stole),
        .queue_size     (queue_size),
        .queue_capacity (queue_capacity),
        .last           (last)
    );

    // task store: address is {core, slot}
    wscs_ram #(
        .WIDTH (TASK_W),
        .DEPTH (MAX_CORES * QUEUE_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );
endmodule
`default_nettype wire

// ===== sv/wscs_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module wscs_ram #(
    parameter int WIDTH = 31,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;
endmodule
`default_nettype wire

// ===== sv/wscs_ctrl.sv =====
// Sequencing state machine for the scheduler commands.
`default_nettype none
module wscs_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire wscs_pkg::dp_stat_t stat,
    output wscs_pkg::dp_cmd_t       cmd
);
    import wscs_pkg::*;

    ctrl_state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                    state_next = S_DISPATCH;
            end
            S_DISPATCH:
            begin
                unique case (stat.cmd)
                    CMD_RUN:
                    begin
                        if (!stat.cid_ok)
                            state_next = S_EMIT;
                        else if (stat.cid_has)
                            state_next = S_RUN_POP;
                        else
                            state_next = S_STEAL_CHK;
                    end
                    CMD_SLEEP:
                    begin
                        if (!stat.cid_ok || !stat.cid_has || stat.single_core)
                            state_next = S_EMIT;
                        else
                            state_next = S_SLEEP_SEL;
                    end
                    CMD_SHUTDOWN:
                    begin
                        state_next = stat.total_zero ? S_EMIT : S_SHUT_SCAN;
                    end
                    default:
                    begin
                        state_next = S_EMIT;
                    end
                endcase
            end
            S_RUN_POP:   state_next = S_STEAL_CHK;
            S_STEAL_CHK: state_next = stat.run_steal ? S_STEAL_WR : S_EMIT;
            S_STEAL_WR:  state_next = S_EMIT;
            S_SLEEP_SEL: state_next = stat.sleep_full ? S_EMIT : S_SLEEP_WR;
            S_SLEEP_WR:  state_next = S_EMIT;
            S_SHUT_SCAN:
            begin
                if (!stat.shut_cur_empty)
                    state_next = S_SHUT_POP;
            end
            S_SHUT_POP:  state_next = S_EMIT;
            S_EMIT:
            begin
                if (stat.out_free)
                begin
                    if (stat.last_now)
                        state_next = S_IDLE;
                    else if (stat.cmd == CMD_SLEEP)
                        state_next = S_SLEEP_SEL;
                    else
                        state_next = S_SHUT_SCAN;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // datapath commands
    always_comb
    begin
        cmd.op   = DP_NOP;
        cmd.emit = 1'b0;
        in_ready = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                    cmd.op = DP_LATCH;
            end
            S_DISPATCH:
            begin
                unique case (stat.cmd)
                    CMD_SPAWN:
                        cmd.op = stat.spawn_fail ? DP_FAIL : DP_SPAWN;
                    CMD_RUN:
                        cmd.op = stat.cid_ok ? DP_RUN_INIT : DP_FAIL;
                    CMD_SLEEP:
                    begin
                        if (!stat.cid_ok)
                            cmd.op = DP_FAIL;
                        else if (!stat.cid_has)
                            cmd.op = DP_SLEEP_EMPTY;
                        else if (stat.single_core)
                            cmd.op = DP_FAIL;
                    end
                    CMD_SHUTDOWN:
                        cmd.op = stat.total_zero ? DP_SHUT_EMPTY : DP_SHUT_START;
                    CMD_QUERY:
                        cmd.op = stat.cid_ok ? DP_QUERY : DP_FAIL;
                    default:
                        cmd.op = DP_FAIL;
                endcase
            end
            S_RUN_POP:   cmd.op = DP_RUN_POP;
            S_STEAL_CHK:
            begin
                if (stat.run_steal)
                    cmd.op = DP_STEAL_POP;
            end
            S_STEAL_WR:  cmd.op = DP_STEAL_PUSH;
            S_SLEEP_SEL: cmd.op = stat.sleep_full ? DP_FAIL : DP_SLEEP_POP;
            S_SLEEP_WR:  cmd.op = DP_SLEEP_PUSH;
            S_SHUT_SCAN: cmd.op = stat.shut_cur_empty ? DP_SHUT_NEXT : DP_NOP;
            S_SHUT_POP:  cmd.op = DP_SHUT_POP;
            S_EMIT:      cmd.emit = stat.out_free;
            default:     cmd.op = DP_NOP;
        endcase
    end
endmodule
`default_nettype wire

// ===== sv/wscs_dp.sv =====
// Per-core queue state, selection logic, store access and result register.
`default_nettype none
module wscs_dp (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire wscs_pkg::dp_cmd_t              cmd,
    output wscs_pkg::dp_stat_t                  stat,
    input  wire logic                           cfg_wr_en,
    input  wire logic [wscs_pkg::ACT_W-1:0]     cfg_wr_data,
    input  wire logic [wscs_pkg::CMD_W-1:0]     command,
    input  wire logic [wscs_pkg::CORE_W-1:0]    core_id,
    input  wire logic [wscs_pkg::TASK_W-1:0]    task_id,
    output logic                                mem_we,
    output logic      [wscs_pkg::ADDR_W-1:0]    mem_waddr,
    output logic      [wscs_pkg::TASK_W-1:0]    mem_wdata,
    output logic      [wscs_pkg::ADDR_W-1:0]    mem_raddr,
    input  wire logic [wscs_pkg::TASK_W-1:0]    mem_rdata,
    output logic                                out_valid,
    input  wire logic                           out_ready,
    output logic      [wscs_pkg::STAT_W-1:0]    status,
    output logic      [wscs_pkg::CORE_W-1:0]    core_id_out,
    output logic      [wscs_pkg::TASK_W-1:0]    task_out,
    output logic      [wscs_pkg::CORE_W-1:0]    other_core,
    output logic                                stole,
    output logic      [wscs_pkg::SIZE_W-1:0]    queue_size,
    output logic      [wscs_pkg::SIZE_W-1:0]    queue_capacity,
    output logic                                last
);
    import wscs_pkg::*;

    // queue state
    logic [SIZE_W-1:0] size_reg [MAX_CORES];
    logic [SIZE_W-1:0] size_next [MAX_CORES];
    logic [SIZE_W-1:0] cap_reg  [MAX_CORES];
    logic [SIZE_W-1:0] cap_next [MAX_CORES];
    logic [PTR_W-1:0]  head_reg [MAX_CORES];
    logic [PTR_W-1:0]  head_next [MAX_CORES];
    logic [PTR_W-1:0]  tail_reg [MAX_CORES];
    logic [PTR_W-1:0]  tail_next [MAX_CORES];
    logic [ACT_W-1:0]  active_reg, active_next;

    // latched command
    cmd_t              cmd_reg;
    logic [CORE_W-1:0] cid_reg;
    logic [TASK_W-1:0] task_reg;
    logic [CORE_W-1:0] tgt_reg, tgt_next;
    logic [CORE_W-1:0] idx_reg, idx_next;

    // pending result
    res_status_t       res_status_reg, res_status_next;
    logic [CORE_W-1:0] res_core_reg, res_core_next;
    logic [TASK_W-1:0] res_task_reg, res_task_next;
    logic [CORE_W-1:0] res_other_reg, res_other_next;
    logic              res_stole_reg, res_stole_next;
    logic              res_report_reg, res_report_next;

    // output register
    logic              out_valid_reg, out_valid_next;
    logic [STAT_W-1:0] o_status_reg;
    logic [CORE_W-1:0] o_core_reg;
    logic [TASK_W-1:0] o_task_reg;
    logic [CORE_W-1:0] o_other_reg;
    logic              o_stole_reg;
    logic [SIZE_W-1:0] o_size_reg;
    logic [SIZE_W-1:0] o_cap_reg;
    logic              o_last_reg;

    logic [CORE_W-1:0] least_c, most_c, alt_c, sleep_tgt;
    logic              alt_found;
    logic [TOT_W-1:0]  total;
    logic              last_now;
    logic [ACT_W-1:0]  cfg_sat;

    // least / most loaded over active cores, lowest index on ties
    always_comb
    begin
        least_c   = '0;
        most_c    = '0;
        alt_c     = '0;
        alt_found = 1'b0;
        total     = '0;
        for (int i = 0; i < MAX_CORES; i++)
        begin
            total = total + TOT_W'(size_reg[i]);
            if (ACT_W'(i) < active_reg)
            begin
                if (size_reg[i] < size_reg[least_c])
                    least_c = CORE_W'(i);
                if (size_reg[i] > size_reg[most_c])
                    most_c = CORE_W'(i);
                // sleep fallback: last of the smallest among other cores
                if (CORE_W'(i) != cid_reg &&
                    (!alt_found || size_reg[i] <= size_reg[alt_c]))
                begin
                    alt_c     = CORE_W'(i);
                    alt_found = 1'b1;
                end
            end
        end
        sleep_tgt = (least_c == cid_reg) ? alt_c : least_c;
    end

    always_comb
    begin
        case (res_status_reg)
            ST_MOVED:   last_now = (size_reg[cid_reg] == '0);
            ST_DELETED: last_now = (total == '0);
            default:    last_now = 1'b1;
        endcase
    end

    always_comb
    begin
        stat.cmd            = cmd_reg;
        stat.cid_ok         = ({1'b0, cid_reg} < active_reg);
        stat.cid_has        = (size_reg[cid_reg] != '0);
        stat.spawn_fail     = (task_reg == '0) ||
                              (size_reg[least_c] >= SIZE_W'(QUEUE_DEPTH));
        stat.single_core    = (active_reg < ACT_W'(2));
        stat.total_zero     = (total == '0);
        stat.run_steal      = (size_reg[cid_reg] == '0) && (size_reg[most_c] != '0);
        stat.sleep_full     = (size_reg[sleep_tgt] >= SIZE_W'(QUEUE_DEPTH));
        stat.shut_cur_empty = (size_reg[idx_reg] == '0);
        stat.last_now       = last_now;
        stat.out_free       = !out_valid_reg || out_ready;
    end

    always_comb
    begin
        if (cfg_wr_data == '0)
            cfg_sat = ACT_W'(1);
        else if (cfg_wr_data > ACT_W'(MAX_CORES))
            cfg_sat = ACT_W'(MAX_CORES);
        else
            cfg_sat = cfg_wr_data;
    end

    // store address selection
    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = '0;
        mem_wdata = mem_rdata;
        mem_raddr = '0;
        case (cmd.op)
            DP_RUN_INIT:   mem_raddr = {cid_reg, head_reg[cid_reg]};
            DP_STEAL_POP:  mem_raddr = {most_c, tail_reg[most_c] - PTR_W'(1)};
            DP_SLEEP_POP:  mem_raddr = {cid_reg, tail_reg[cid_reg] - PTR_W'(1)};
            DP_SHUT_NEXT:  mem_raddr = {idx_reg, head_reg[idx_reg]};
            DP_NOP:        mem_raddr = {idx_reg, head_reg[idx_reg]};
            DP_SPAWN:
            begin
                mem_we    = 1'b1;
                mem_waddr = {least_c, tail_reg[least_c]};
                mem_wdata = task_reg;
            end
            DP_STEAL_PUSH:
            begin
                mem_we    = 1'b1;
                mem_waddr = {cid_reg, tail_reg[cid_reg]};
            end
            DP_SLEEP_PUSH:
            begin
                mem_we    = 1'b1;
                mem_waddr = {tgt_reg, tail_reg[tgt_reg]};
            end
            default:       mem_raddr = '0;
        endcase
    end

    // state updates
    always_comb
    begin
        size_next       = size_reg;
        cap_next        = cap_reg;
        head_next       = head_reg;
        tail_next       = tail_reg;
        active_next     = active_reg;
        tgt_next        = tgt_reg;
        idx_next        = idx_reg;
        res_status_next = res_status_reg;
        res_core_next   = res_core_reg;
        res_task_next   = res_task_reg;
        res_other_next  = res_other_reg;
        res_stole_next  = res_stole_reg;
        res_report_next = res_report_reg;

        case (cmd.op)
            DP_FAIL:
            begin
                res_status_next = ST_FAIL;
                res_core_next   = '0;
                res_task_next   = '0;
                res_other_next  = '0;
                res_stole_next  = 1'b0;
                res_report_next = 1'b0;
            end
            DP_SPAWN:
            begin
                cap_next[least_c]  = grow_cap(size_reg[least_c], cap_reg[least_c]);
                tail_next[least_c] = tail_reg[least_c] + PTR_W'(1);
                size_next[least_c] = size_reg[least_c] + SIZE_W'(1);
                res_status_next    = ST_ASSIGNED;
                res_core_next      = least_c;
                res_task_next      = task_reg;
                res_other_next     = '0;
                res_stole_next     = 1'b0;
                res_report_next    = 1'b1;
            end
            DP_RUN_INIT:
            begin
                res_status_next = ST_IDLE;
                res_core_next   = cid_reg;
                res_task_next   = '0;
                res_other_next  = '0;
                res_stole_next  = 1'b0;
                res_report_next = 1'b1;
            end
            DP_RUN_POP:
            begin
                cap_next[cid_reg]  = shrink_cap(size_reg[cid_reg], cap_reg[cid_reg]);
                head_next[cid_reg] = head_reg[cid_reg] + PTR_W'(1);
                size_next[cid_reg] = size_reg[cid_reg] - SIZE_W'(1);
                res_status_next    = ST_RAN;
                res_task_next      = mem_rdata;
            end
            DP_STEAL_POP:
            begin
                cap_next[most_c]  = shrink_cap(size_reg[most_c], cap_reg[most_c]);
                tail_next[most_c] = tail_reg[most_c] - PTR_W'(1);
                size_next[most_c] = size_reg[most_c] - SIZE_W'(1);
                res_other_next    = most_c;
            end
            DP_STEAL_PUSH:
            begin
                cap_next[cid_reg]  = grow_cap(size_reg[cid_reg], cap_reg[cid_reg]);
                tail_next[cid_reg] = tail_reg[cid_reg] + PTR_W'(1);
                size_next[cid_reg] = size_reg[cid_reg] + SIZE_W'(1);
                res_stole_next     = 1'b1;
            end
            DP_SLEEP_EMPTY, DP_QUERY:
            begin
                res_status_next = (cmd.op == DP_QUERY) ? ST_QUERY : ST_NO_MOVE;
                res_core_next   = cid_reg;
                res_task_next   = '0;
                res_other_next  = '0;
                res_stole_next  = 1'b0;
                res_report_next = 1'b1;
            end
            DP_SLEEP_POP:
            begin
                cap_next[cid_reg]  = shrink_cap(size_reg[cid_reg], cap_reg[cid_reg]);
                tail_next[cid_reg] = tail_reg[cid_reg] - PTR_W'(1);
                size_next[cid_reg] = size_reg[cid_reg] - SIZE_W'(1);
                tgt_next           = sleep_tgt;
            end
            DP_SLEEP_PUSH:
            begin
                cap_next[tgt_reg]  = grow_cap(size_reg[tgt_reg], cap_reg[tgt_reg]);
                tail_next[tgt_reg] = tail_reg[tgt_reg] + PTR_W'(1);
                size_next[tgt_reg] = size_reg[tgt_reg] + SIZE_W'(1);
                res_status_next    = ST_MOVED;
                res_core_next      = cid_reg;
                res_task_next      = mem_rdata;
                res_other_next     = tgt_reg;
                res_stole_next     = 1'b0;
                res_report_next    = 1'b1;
            end
            DP_SHUT_EMPTY:
            begin
                res_status_next = ST_NO_DEL;
                res_core_next   = '0;
                res_task_next   = '0;
                res_other_next  = '0;
                res_stole_next  = 1'b0;
                res_report_next = 1'b0;
            end
            DP_SHUT_START: idx_next = '0;
            DP_SHUT_NEXT:  idx_next = idx_reg + CORE_W'(1);
            DP_SHUT_POP:
            begin
                cap_next[idx_reg]  = shrink_cap(size_reg[idx_reg], cap_reg[idx_reg]);
                head_next[idx_reg] = head_reg[idx_reg] + PTR_W'(1);
                size_next[idx_reg] = size_reg[idx_reg] - SIZE_W'(1);
                res_status_next    = ST_DELETED;
                res_core_next      = idx_reg;
                res_task_next      = mem_rdata;
                res_other_next     = '0;
                res_stole_next     = 1'b0;
                res_report_next    = 1'b1;
            end
            default: idx_next = idx_reg;
        endcase

        if (cfg_wr_en)
        begin
            active_next = cfg_sat;
            for (int i = 0; i < MAX_CORES; i++)
            begin
                size_next[i] = '0;
                cap_next[i]  = CAP_RESET;
                head_next[i] = '0;
                tail_next[i] = '0;
            end
        end
    end

    always_comb
    begin
        if (cmd.emit)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_CORES; i++)
            begin
                size_reg[i] <= '0;
                cap_reg[i]  <= CAP_RESET;
                head_reg[i] <= '0;
                tail_reg[i] <= '0;
            end
            active_reg    <= ACT_W'(MAX_CORES);
            out_valid_reg <= 1'b0;
            idx_reg       <= '0;
            tgt_reg       <= '0;
        end
        else
        begin
            size_reg      <= size_next;
            cap_reg       <= cap_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            active_reg    <= active_next;
            out_valid_reg <= out_valid_next;
            idx_reg       <= idx_next;
            tgt_reg       <= tgt_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.op == DP_LATCH)
        begin
            cmd_reg  <= cmd_t'(command);
            cid_reg  <= core_id;
            task_reg <= task_id;
        end
        res_status_reg <= res_status_next;
        res_core_reg   <= res_core_next;
        res_task_reg   <= res_task_next;
        res_other_reg  <= res_other_next;
        res_stole_reg  <= res_stole_next;
        res_report_reg <= res_report_next;
        if (cmd.emit)
        begin
            o_status_reg <= res_status_reg;
            o_core_reg   <= res_core_reg;
            o_task_reg   <= res_task_reg;
            o_other_reg  <= res_other_reg;
            o_stole_reg  <= res_stole_reg;
            o_size_reg   <= res_report_reg ? size_reg[res_core_reg] : '0;
            o_cap_reg    <= res_report_reg ? cap_reg[res_core_reg] : '0;
            o_last_reg   <= last_now;
        end
    end

    assign out_valid      = out_valid_reg;
    assign status         = o_status_reg;
    assign core_id_out    = o_core_reg;
    assign task_out       = o_task_reg;
    assign other_core     = o_other_reg;
    assign stole          = o_stole_reg;
    assign queue_size     = o_size_reg;
    assign queue_capacity = o_cap_reg;
    assign last           = o_last_reg;
endmodule
`default_nettype wire

// ===== sv/wscs_checker.sv =====
// Port-level checks for the scheduler, bound to the top level.
`default_nettype none
module wscs_checker (
    input wire logic                        clk,
    input wire logic                        rst_n,
    input wire logic                        out_valid,
    input wire logic                        out_ready,
    input wire logic [wscs_pkg::STAT_W-1:0] status,
    input wire logic [wscs_pkg::SIZE_W-1:0] queue_size,
    input wire logic [wscs_pkg::SIZE_W-1:0] queue_capacity,
    input wire logic                        last
);
    import wscs_pkg::*;

    // failures and empty shutdown carry no core report
    a_fail_no_report: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == ST_FAIL || status == ST_NO_DEL)
        |-> queue_size == '0 && queue_capacity == '0)
        else $error("report fields set on failure result");

    // single-result commands always end their transaction group
    a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == ST_ASSIGNED || status == ST_QUERY ||
                      status == ST_RAN || status == ST_IDLE)
        |-> last)
        else $error("single-result command without last");

    // on query and assign results, the reported size never exceeds the modeled capacity
    a_size_cap: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == ST_QUERY || status == ST_ASSIGNED)
        |-> queue_size <= queue_capacity)
        else $error("queue size above capacity");

    // stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(status) && $stable(last))
        else $error("result changed while stalled");
endmodule

bind work_stealing_core_scheduler_unit wscs_checker u_wscs_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .status         (status),
    .queue_size     (queue_size),
    .queue_capacity (queue_capacity),
    .last           (last)
);
`default_nettype wire

// ===== dv/work_stealing_core_scheduler_unit_tb.sv =====
// Self-checking testbench for the work-stealing core scheduler unit.
`timescale 1ns / 1ps
module work_stealing_core_scheduler_unit_tb;
    import wscs_pkg::*;

    // command codes with no operation behind them; the block must fail them
    localparam logic [CMD_W-1:0] CMD_UNKNOWN_LO = 3'd5;
    localparam logic [CMD_W-1:0] CMD_UNKNOWN_HI = 3'd7;
    localparam logic [TASK_W-1:0] TASK_MAX = {TASK_W{1'b1}};

    typedef struct {
        logic [CMD_W-1:0]  cmd;
        logic [CORE_W-1:0] cid;
        logic [TASK_W-1:0] tid;
    } sched_cmd_t;

    typedef struct {
        res_status_t       st;
        logic [CORE_W-1:0] core;
        logic [TASK_W-1:0] tsk;
        logic [CORE_W-1:0] other;
        logic              stl;
        logic [SIZE_W-1:0] qsize;
        logic [SIZE_W-1:0] qcap;
        logic              lst;
    } sched_result_t;

    logic                clk;
    logic                rst_n;
    logic                cfg_wr_en;
    logic [ACT_W-1:0]    cfg_wr_data;
    logic                in_valid;
    logic                in_ready;
    logic [CMD_W-1:0]    command;
    logic [CORE_W-1:0]   core_id;
    logic [TASK_W-1:0]   task_id;
    logic                out_valid;
    logic                out_ready;
    logic [STAT_W-1:0]   status;
    logic [CORE_W-1:0]   core_id_out;
    logic [TASK_W-1:0]   task_out;
    logic [CORE_W-1:0]   other_core;
    logic                stole;
    logic [SIZE_W-1:0]   queue_size;
    logic [SIZE_W-1:0]   queue_capacity;
    logic                last;

    work_stealing_core_scheduler_unit uut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .command        (command),
        .core_id        (core_id),
        .task_id        (task_id),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .status         (status),
        .core_id_out    (core_id_out),
        .task_out       (task_out),
        .other_core     (other_core),
        .stole          (stole),
        .queue_size     (queue_size),
        .queue_capacity (queue_capacity),
        .last           (last)
    );

    // ------------------------------------------------------------------
    // Shadow scheduler state, kept in step with each accepted command
    // ------------------------------------------------------------------
    logic [TASK_W-1:0] shadow_store [MAX_CORES][QUEUE_DEPTH];
    int                shadow_head  [MAX_CORES];
    int                shadow_tail  [MAX_CORES];
    int                shadow_size  [MAX_CORES];
    int                shadow_cap   [MAX_CORES];
    int                shadow_cores;

    sched_cmd_t    pending_cmds [$];
    sched_result_t expected_results [$];

    int n_errors;
    int n_cmds_sent;
    int n_results_seen;
    int n_cfg_writes;

    function automatic void clear_shadow();
        for (int i = 0; i < MAX_CORES; i++)
        begin
            shadow_head[i] = 0;
            shadow_tail[i] = 0;
            shadow_size[i] = 0;
            shadow_cap[i]  = 4;
        end
    endfunction

    function automatic void push_task(int c, logic [TASK_W-1:0] t);
        if (shadow_size[c] == shadow_cap[c])
            shadow_cap[c] = (shadow_cap[c] * 2 > QUEUE_DEPTH) ? QUEUE_DEPTH : shadow_cap[c] * 2;
        shadow_store[c][shadow_tail[c]] = t;
        shadow_tail[c] = (shadow_tail[c] + 1) % QUEUE_DEPTH;
        shadow_size[c]++;
    endfunction

    // shrink check uses the size before the pop
    function automatic logic [TASK_W-1:0] pop_task(int c, bit from_back);
        logic [TASK_W-1:0] t;
        if (shadow_size[c] == shadow_cap[c] / 4)
            shadow_cap[c] = shadow_cap[c] / 2;
        if (from_back)
        begin
            shadow_tail[c] = (shadow_tail[c] + QUEUE_DEPTH - 1) % QUEUE_DEPTH;
            t = shadow_store[c][shadow_tail[c]];
        end
        else
        begin
            t = shadow_store[c][shadow_head[c]];
            shadow_head[c] = (shadow_head[c] + 1) % QUEUE_DEPTH;
        end
        shadow_size[c]--;
        return t;
    endfunction

    function automatic int pick_core(bit most);
        int best;
        best = 0;
        for (int i = 1; i < shadow_cores; i++)
            if (most ? (shadow_size[i] > shadow_size[best]) : (shadow_size[i] < shadow_size[best]))
                best = i;
        return best;
    endfunction

    function automatic void add_result(res_status_t st, int c, logic [TASK_W-1:0] t,
                                       int oth, bit stl, bit report, bit lst);
        sched_result_t r;
        r.st    = st;
        r.core  = c[CORE_W-1:0];
        r.tsk   = t;
        r.other = oth[CORE_W-1:0];
        r.stl   = stl;
        r.qsize = report ? shadow_size[c][SIZE_W-1:0] : '0;
        r.qcap  = report ? shadow_cap[c][SIZE_W-1:0] : '0;
        r.lst   = lst;
        expected_results.push_back(r);
    endfunction

    function automatic void add_failure();
        add_result(ST_FAIL, 0, '0, 0, 0, 0, 1);
    endfunction

    function automatic void predict_command(sched_cmd_t it);
        int                c;
        int                tgt;
        int                total;
        int                donor;
        bit                stl;
        bit                found;
        logic [TASK_W-1:0] t;
        res_status_t       st;
        c = it.cid;
        case (it.cmd)
            CMD_SPAWN:
            begin
                tgt = pick_core(0);
                if (it.tid == '0 || shadow_size[tgt] >= QUEUE_DEPTH)
                    add_failure();
                else
                begin
                    push_task(tgt, it.tid);
                    add_result(ST_ASSIGNED, tgt, it.tid, 0, 0, 1, 1);
                end
            end
            CMD_RUN:
            begin
                if (c >= shadow_cores)
                    add_failure();
                else
                begin
                    t = '0; st = ST_IDLE; stl = 0; donor = 0;
                    if (shadow_size[c] > 0)
                    begin
                        t = pop_task(c, 0);
                        st = ST_RAN;
                    end
                    // core drained: steal the back task of the busiest core
                    if (shadow_size[c] == 0)
                    begin
                        tgt = pick_core(1);
                        if (shadow_size[tgt] > 0)
                        begin
                            push_task(c, pop_task(tgt, 1));
                            stl = 1;
                            donor = tgt;
                        end
                    end
                    add_result(st, c, t, donor, stl, 1, 1);
                end
            end
            CMD_SLEEP:
            begin
                if (c >= shadow_cores)
                    add_failure();
                else if (shadow_size[c] == 0)
                    add_result(ST_NO_MOVE, c, '0, 0, 0, 1, 1);
                else if (shadow_cores < 2)
                    add_failure();
                else
                begin
                    while (shadow_size[c] > 0)
                    begin
                        tgt = pick_core(0);
                        if (tgt == c)
                        begin
                            found = 0;
                            for (int i = 0; i < shadow_cores; i++)
                                if (i != c && (!found || shadow_size[i] <= shadow_size[tgt]))
                                begin
                                    tgt = i;
                                    found = 1;
                                end
                        end
                        // target full: report failure, leave the rest in place
                        if (shadow_size[tgt] >= QUEUE_DEPTH)
                        begin
                            add_failure();
                            break;
                        end
                        t = pop_task(c, 1);
                        push_task(tgt, t);
                        add_result(ST_MOVED, c, t, tgt, 0, 1, shadow_size[c] == 0);
                    end
                end
            end
            CMD_SHUTDOWN:
            begin
                total = 0;
                for (int i = 0; i < shadow_cores; i++)
                    total += shadow_size[i];
                if (total == 0)
                    add_result(ST_NO_DEL, 0, '0, 0, 0, 0, 1);
                else
                    for (int i = 0; i < shadow_cores; i++)
                        while (shadow_size[i] > 0)
                        begin
                            t = pop_task(i, 0);
                            total--;
                            add_result(ST_DELETED, i, t, 0, 0, 1, total == 0);
                        end
            end
            CMD_QUERY:
            begin
                if (c >= shadow_cores)
                    add_failure();
                else
                    add_result(ST_QUERY, c, '0, 0, 0, 1, 1);
            end
            default: add_failure();
        endcase
    endfunction

    // mostly short gaps, now and then a long one, often none at all
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 20);
    endfunction

    // ------------------------------------------------------------------
    // Clock, reset
    // ------------------------------------------------------------------
    initial clk = 1'b0;
    always #4 clk = ~clk;

    // ------------------------------------------------------------------
    // Command driver: holds valid and payload until the transaction lands
    // ------------------------------------------------------------------
    int drv_gap;

    always @(posedge clk or negedge rst_n)
    begin
        sched_cmd_t it;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            command  <= '0;
            core_id  <= '0;
            task_id  <= '0;
            drv_gap   = 0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                it.cmd = command;
                it.cid = core_id;
                it.tid = task_id;
                predict_command(it);
                n_cmds_sent++;
            end
            if (in_valid && !in_ready)
                ; // stalled: keep everything as is
            else if (drv_gap > 0)
            begin
                drv_gap--;
                in_valid <= 1'b0;
            end
            else if (pending_cmds.size() > 0)
            begin
                it = pending_cmds.pop_front();
                command  <= it.cmd;
                core_id  <= it.cid;
                task_id  <= it.tid;
                in_valid <= 1'b1;
                drv_gap   = pick_gap();
            end
            else
                in_valid <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Result monitor with random back-pressure
    // ------------------------------------------------------------------
    int mon_stall;

    function automatic void check_field(string name, longint unsigned exp_v,
                                        longint unsigned act_v);
        if (exp_v != act_v)
        begin
            $error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
            n_errors++;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        sched_result_t e;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            mon_stall  = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                n_results_seen++;
                if (expected_results.size() == 0)
                begin
                    $error("result transaction with none expected (status %0d)", status);
                    n_errors++;
                end
                else
                begin
                    e = expected_results.pop_front();
                    check_field("status", e.st, status);
                    check_field("core_id_out", e.core, core_id_out);
                    check_field("task_out", e.tsk, task_out);
                    check_field("other_core", e.other, other_core);
                    check_field("stole", e.stl, stole);
                    check_field("queue_size", e.qsize, queue_size);
                    check_field("queue_capacity", e.qcap, queue_capacity);
                    check_field("last", e.lst, last);
                end
            end
            if (mon_stall > 0)
            begin
                mon_stall--;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= 1'b1;
                mon_stall  = pick_gap();
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    task automatic queue_cmd(logic [CMD_W-1:0] cmd, int cid, logic [TASK_W-1:0] tid);
        sched_cmd_t it;
        it.cmd = cmd;
        it.cid = cid[CORE_W-1:0];
        it.tid = tid;
        pending_cmds.push_back(it);
    endtask

    // drain everything, let the block settle, then touch the register
    task automatic write_cores(logic [ACT_W-1:0] v);
        int n;
        while (pending_cmds.size() > 0 || in_valid || expected_results.size() > 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        n = (v == 0) ? 1 : ((v > MAX_CORES) ? MAX_CORES : v);
        shadow_cores = n;
        clear_shadow();
        n_cfg_writes++;
    endtask

    function automatic logic [TASK_W-1:0] rand_task();
        logic [TASK_W-1:0] t;
        if ($urandom_range(0, 15) == 0)
            return '0;
        t = TASK_W'($urandom);
        return (t == '0) ? TASK_W'(1) : t;
    endfunction

    // spawn_bias raises the spawn share so the store can fill up
    task automatic queue_random(int count, int spawn_bias);
        int r;
        for (int k = 0; k < count; k++)
        begin
            r = $urandom_range(0, 99);
            if (r < 40 + spawn_bias)
                queue_cmd(CMD_SPAWN, $urandom_range(0, 3), rand_task());
            else if (r < 65 + spawn_bias / 2)
                queue_cmd(CMD_RUN, $urandom_range(0, 3), TASK_W'($urandom));
            else if (r < 78)
                queue_cmd(CMD_SLEEP, $urandom_range(0, 3), TASK_W'($urandom));
            else if (r < 82)
                queue_cmd(CMD_SHUTDOWN, $urandom_range(0, 3), TASK_W'($urandom));
            else if (r < 95)
                queue_cmd(CMD_QUERY, $urandom_range(0, 3), TASK_W'($urandom));
            else
                queue_cmd(CMD_W'($urandom_range(CMD_UNKNOWN_LO, CMD_UNKNOWN_HI)),
                          $urandom_range(0, 3), TASK_W'($urandom));
        end
    endtask

    initial
    begin
        rst_n        = 1'b0;
        cfg_wr_en    = 1'b0;
        cfg_wr_data  = '0;
        n_errors       = 0;
        n_cmds_sent    = 0;
        n_results_seen = 0;
        n_cfg_writes   = 0;
        shadow_cores   = MAX_CORES;
        clear_shadow();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // directed: empty cases, zero task, extreme ids, steal, sleep, unknown codes
        queue_cmd(CMD_QUERY, 3, '0);
        queue_cmd(CMD_RUN, 0, '0);
        queue_cmd(CMD_SLEEP, 1, '0);
        queue_cmd(CMD_SHUTDOWN, 0, '0);
        queue_cmd(CMD_SPAWN, 0, '0);
        queue_cmd(CMD_SPAWN, 3, TASK_MAX);
        for (int i = 1; i <= 7; i++)
            queue_cmd(CMD_SPAWN, 0, TASK_W'(i));
        queue_cmd(CMD_RUN, 1, '0);
        queue_cmd(CMD_RUN, 1, '0);
        queue_cmd(CMD_SLEEP, 0, '0);
        queue_cmd(CMD_QUERY, 2, '0);
        queue_cmd(CMD_UNKNOWN_LO, 0, TASK_MAX);
        queue_cmd(CMD_UNKNOWN_HI, 3, '0);
        queue_cmd(CMD_SHUTDOWN, 0, '0);

        // zero saturates to one core: single-core sleep, out-of-range core, full store
        write_cores(3'd0);
        queue_cmd(CMD_SPAWN, 0, TASK_W'(9));
        queue_cmd(CMD_SLEEP, 0, '0);
        queue_cmd(CMD_RUN, 1, '0);
        for (int i = 0; i < 16; i++)
            queue_cmd(CMD_SPAWN, 0, rand_task() | TASK_W'(1));
        queue_cmd(CMD_SHUTDOWN, 0, '0);

        // two cores filled solid, then a sleep that hits a full target
        write_cores(3'd2);
        for (int i = 0; i < 32; i++)
            queue_cmd(CMD_SPAWN, 0, TASK_W'(i + 100));
        queue_cmd(CMD_SLEEP, 0, '0);
        queue_cmd(CMD_SHUTDOWN, 0, '0);

        // random phases over several core counts, saturating value included
        write_cores(3'd7);
        queue_random(10, 0);
        write_cores(3'd3);
        queue_random(10, 20);
        write_cores(3'd1);
        queue_random(8, 30);
        write_cores(3'd2);
        queue_random(10, 30);
        write_cores(3'd4);
        queue_random(10, 10);

        while (pending_cmds.size() > 0 || in_valid || expected_results.size() > 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        $display("Covered %0d commands, %0d result transactions, %0d core-count writes",
                 n_cmds_sent, n_results_seen, n_cfg_writes);
        $display("including full stores, steals, sleeps, shutdowns and failure cases");
        if (n_errors == 0 && expected_results.size() == 0)
            $display("work_stealing_core_scheduler_unit_tb: PASS");
        else
        begin
            if (expected_results.size() > 0)
                $error("%0d expected results never arrived", expected_results.size());
            $display("work_stealing_core_scheduler_unit_tb: FAIL");
        end
        $finish;
    end

    // watchdog
    initial
    begin
        #5ms;
        $display("timeout");
        $display("work_stealing_core_scheduler_unit_tb: FAIL");
        $finish;
    end

endmodule
